// ----- hw/rtl/fbnp_pkg.sv -----
// Shared types and constants for the file block to node path translator.
// Holds the default tree geometry, region codes, depth codes and item structs.
// No dependencies.
package fbnp_pkg;

    // Default tree geometry
    localparam int DefInodeAddrs = 923;
    localparam int DefBlockAddrs = 1018;
    localparam int DefBlockNids  = 1018;

    // Field widths of the request and response items
    localparam int IndexW = 32;
    localparam int DepthW = 2;
    localparam int SlotW  = 10;
    localparam int Off1W  = 11;
    localparam int OffW   = 20;

    // Where a block index lands in the inode address tree
    typedef enum logic [2:0] {
        REGION_DIRECT    = 3'd0,
        REGION_DNODE0    = 3'd1,
        REGION_DNODE1    = 3'd2,
        REGION_IND0      = 3'd3,
        REGION_IND1      = 3'd4,
        REGION_DIND      = 3'd5,
        REGION_RANGE_ERR = 3'd6
    } region_t;

    // Tree depth codes
    localparam logic [DepthW-1:0] DEPTH_DIRECT = 2'd0;
    localparam logic [DepthW-1:0] DEPTH_DNODE  = 2'd1;
    localparam logic [DepthW-1:0] DEPTH_IND    = 2'd2;
    localparam logic [DepthW-1:0] DEPTH_DIND   = 2'd3;

    typedef struct packed {
        logic [IndexW-1:0] block_index;
    } in_item_t;

    typedef struct packed {
        logic              out_of_range;
        logic [DepthW-1:0] depth;
        logic [SlotW-1:0]  slot0;
        logic [SlotW-1:0]  slot1;
        logic [SlotW-1:0]  slot2;
        logic [SlotW-1:0]  slot3;
        logic [Off1W-1:0]  node_off1;
        logic [OffW-1:0]   node_off2;
        logic [OffW-1:0]   node_off3;
    } out_item_t;

endpackage

// ----- hw/rtl/fbnp_stream_if.sv -----
// Valid/ready stream interface with a typed payload.
// Used for the request and response channels; no dependencies.
interface fbnp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/file_block_to_node_path.sv -----
// Top level of the file block to node path translator.
// Depends on fbnp_pkg, fbnp_stream_if, fbnp_classify, fbnp_divide, fbnp_assemble.
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------------
//   req     | in        | block_index
//   rsp     | out       | out_of_range, depth, slot0..3, node_off1..3
//
// One transaction per cycle sustained while the response is not stalled; a
// response passes in order through the five register stages: input register,
// classification, reciprocal quotient, remainder and second quotient, result.
// Each stage takes new data when empty or when the next one moves, so a stalled
// response still lets earlier stages fill. Reset clears only the stage valids.
module file_block_to_node_path #(
    parameter int INODE_ADDRS = fbnp_pkg::DefInodeAddrs,
    parameter int BLOCK_ADDRS = fbnp_pkg::DefBlockAddrs,
    parameter int BLOCK_NIDS  = fbnp_pkg::DefBlockNids
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fbnp_stream_if.sink          req,
    fbnp_stream_if.source        rsp
);
    import fbnp_pkg::*;

    localparam int RelW = $clog2(BLOCK_ADDRS * BLOCK_NIDS * BLOCK_NIDS);
    localparam int QW   = $clog2(BLOCK_NIDS * BLOCK_NIDS);
    localparam int NW   = $clog2(BLOCK_NIDS);
    localparam int RW   = $clog2(BLOCK_ADDRS);

    logic              cls_valid;
    logic              cls_ready;
    region_t           cls_region;
    logic [SlotW-1:0]  cls_slot0;
    logic [RelW-1:0]   cls_rel;

    logic              div_valid;
    logic              div_ready;
    region_t           div_region;
    logic [SlotW-1:0]  div_slot0;
    logic [RW-1:0]     div_rem;
    logic [QW-1:0]     div_q_all;
    logic [NW-1:0]     div_q_nid;

    out_item_t         rsp_item;

    // Classify the index into a tree region
    fbnp_classify #(
        .INODE_ADDRS (INODE_ADDRS),
        .BLOCK_ADDRS (BLOCK_ADDRS),
        .BLOCK_NIDS  (BLOCK_NIDS)
    ) u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .block_index (req.payload.block_index),
        .out_valid   (cls_valid),
        .out_ready   (cls_ready),
        .region      (cls_region),
        .slot0       (cls_slot0),
        .rel         (cls_rel)
    );

    // Split the region offset into per-level slots
    fbnp_divide #(
        .BLOCK_ADDRS (BLOCK_ADDRS),
        .BLOCK_NIDS  (BLOCK_NIDS)
    ) u_divide (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cls_valid),
        .in_ready   (cls_ready),
        .in_region  (cls_region),
        .in_slot0   (cls_slot0),
        .rel        (cls_rel),
        .out_valid  (div_valid),
        .out_ready  (div_ready),
        .out_region (div_region),
        .out_slot0  (div_slot0),
        .rem_addr   (div_rem),
        .q_all      (div_q_all),
        .q_nid      (div_q_nid)
    );

    // Build and hold the response
    fbnp_assemble #(
        .INODE_ADDRS (INODE_ADDRS),
        .BLOCK_ADDRS (BLOCK_ADDRS),
        .BLOCK_NIDS  (BLOCK_NIDS)
    ) u_assemble (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .region    (div_region),
        .slot0     (div_slot0),
        .rem_addr  (div_rem),
        .q_all     (div_q_all),
        .q_nid     (div_q_nid),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .item      (rsp_item)
    );

    assign rsp.payload = rsp_item;

`ifndef SYNTHESIS
    a_range_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.out_of_range |->
            rsp.payload.depth == DEPTH_DIRECT && rsp.payload.slot0 == '0 &&
            rsp.payload.node_off1 == '0 && rsp.payload.node_off2 == '0)
        else $error("out of range response carries nonzero path fields");

    a_level3_unused: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.depth != DEPTH_DIND |->
            rsp.payload.slot3 == '0 && rsp.payload.node_off3 == '0)
        else $error("third level fields set below double-indirect depth");

    a_direct_flat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.payload.out_of_range &&
        rsp.payload.depth == DEPTH_DIRECT |->
            rsp.payload.slot1 == '0 && rsp.payload.node_off1 == '0)
        else $error("direct block response carries node fields");

    a_dind_chain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.depth == DEPTH_DIND |->
            rsp.payload.node_off3 == OffW'(rsp.payload.node_off2 +
                OffW'(rsp.payload.slot2) + OffW'(1)))
        else $error("double-indirect node offsets do not chain");
`endif

endmodule

// ----- hw/rtl/fbnp_classify.sv -----
// Input register and region classification stage.
// Compares the block index against the region bounds and subtracts the region base.
// Depends on fbnp_pkg.
module fbnp_classify #(
    parameter int INODE_ADDRS = fbnp_pkg::DefInodeAddrs,
    parameter int BLOCK_ADDRS = fbnp_pkg::DefBlockAddrs,
    parameter int BLOCK_NIDS  = fbnp_pkg::DefBlockNids,
    localparam int RelW = $clog2(BLOCK_ADDRS * BLOCK_NIDS * BLOCK_NIDS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fbnp_pkg::IndexW-1:0]   block_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbnp_pkg::region_t             region,
    output logic [fbnp_pkg::SlotW-1:0]    slot0,
    output logic [RelW-1:0]               rel
);
    import fbnp_pkg::*;

    localparam int BndW = IndexW + 1;
    localparam logic [BndW-1:0] Bnd1 = BndW'(INODE_ADDRS);
    localparam logic [BndW-1:0] Bnd2 = BndW'(INODE_ADDRS + BLOCK_ADDRS);
    localparam logic [BndW-1:0] Bnd3 = BndW'(INODE_ADDRS + 2 * BLOCK_ADDRS);
    localparam logic [BndW-1:0] Bnd4 = Bnd3 + BndW'(BLOCK_ADDRS * BLOCK_NIDS);
    localparam logic [BndW-1:0] Bnd5 = Bnd4 + BndW'(BLOCK_ADDRS * BLOCK_NIDS);
    localparam logic [BndW-1:0] Bnd6 =
        Bnd5 + BndW'(BLOCK_ADDRS * BLOCK_NIDS * BLOCK_NIDS);

    logic                 idx_v_reg;
    logic [IndexW-1:0]    idx_reg;
    logic                 idx_ready;
    logic                 cls_v_reg;
    region_t              region_reg;
    region_t              region_next;
    logic [SlotW-1:0]     slot0_reg;
    logic [SlotW-1:0]     slot0_next;
    logic [RelW-1:0]      rel_reg;
    logic [RelW-1:0]      rel_next;
    logic [BndW-1:0]      idx_ext;
    logic [BndW-1:0]      base;
    logic [BndW-1:0]      rel_full;

    // Stage handshakes: a stage takes new data when empty or draining
    assign idx_ready = !cls_v_reg || out_ready;
    assign in_ready  = !idx_v_reg || idx_ready;

    // Hold the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_v_reg <= 1'b0;
        else if (in_ready)
            idx_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            idx_reg <= block_index;
    end

    // Pick the region, its base and the inode slot
    always_comb
    begin
        idx_ext     = {1'b0, idx_reg};
        region_next = REGION_RANGE_ERR;
        base        = '0;
        slot0_next  = '0;
        if (idx_ext < Bnd1)
        begin
            region_next = REGION_DIRECT;
            slot0_next  = SlotW'(idx_reg);
        end
        else if (idx_ext < Bnd2)
        begin
            region_next = REGION_DNODE0;
            base        = Bnd1;
            slot0_next  = SlotW'(INODE_ADDRS + 1);
        end
        else if (idx_ext < Bnd3)
        begin
            region_next = REGION_DNODE1;
            base        = Bnd2;
            slot0_next  = SlotW'(INODE_ADDRS + 2);
        end
        else if (idx_ext < Bnd4)
        begin
            region_next = REGION_IND0;
            base        = Bnd3;
            slot0_next  = SlotW'(INODE_ADDRS + 3);
        end
        else if (idx_ext < Bnd5)
        begin
            region_next = REGION_IND1;
            base        = Bnd4;
            slot0_next  = SlotW'(INODE_ADDRS + 4);
        end
        else if (idx_ext < Bnd6)
        begin
            region_next = REGION_DIND;
            base        = Bnd5;
            slot0_next  = SlotW'(INODE_ADDRS + 5);
        end
        rel_full = idx_ext - base;
        if (region_next == REGION_DIRECT || region_next == REGION_RANGE_ERR)
            rel_next = '0;
        else
            rel_next = rel_full[RelW-1:0];
    end

    // Advance the classified transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cls_v_reg <= 1'b0;
        else if (idx_ready)
            cls_v_reg <= idx_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (idx_v_reg && idx_ready)
        begin
            region_reg <= region_next;
            slot0_reg  <= slot0_next;
            rel_reg    <= rel_next;
        end
    end

    assign out_valid = cls_v_reg;
    assign region    = region_reg;
    assign slot0     = slot0_reg;
    assign rel       = rel_reg;

endmodule

// ----- hw/rtl/fbnp_divide.sv -----
// Two-stage constant division of the region offset.
// Stage one: quotient by BLOCK_ADDRS through an exact reciprocal multiply.
// Stage two: remainder by BLOCK_ADDRS and quotient by BLOCK_NIDS. Depends on fbnp_pkg.
module fbnp_divide #(
    parameter int BLOCK_ADDRS = fbnp_pkg::DefBlockAddrs,
    parameter int BLOCK_NIDS  = fbnp_pkg::DefBlockNids,
    localparam int RelW = $clog2(BLOCK_ADDRS * BLOCK_NIDS * BLOCK_NIDS),
    localparam int QW   = $clog2(BLOCK_NIDS * BLOCK_NIDS),
    localparam int NW   = $clog2(BLOCK_NIDS),
    localparam int RW   = $clog2(BLOCK_ADDRS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbnp_pkg::region_t             in_region,
    input  logic [fbnp_pkg::SlotW-1:0]    in_slot0,
    input  logic [RelW-1:0]               rel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbnp_pkg::region_t             out_region,
    output logic [fbnp_pkg::SlotW-1:0]    out_slot0,
    output logic [RW-1:0]                 rem_addr,
    output logic [QW-1:0]                 q_all,
    output logic [NW-1:0]                 q_nid
);
    import fbnp_pkg::*;

    // Reciprocals exact over the full operand width
    localparam int S1  = RelW + $clog2(BLOCK_ADDRS);
    localparam int PW1 = S1 + QW;
    localparam longint unsigned M1 =
        ((longint'(1) << S1) + longint'(BLOCK_ADDRS) - 1) / BLOCK_ADDRS;
    localparam int S2  = QW + NW;
    localparam int PW2 = S2 + NW;
    localparam longint unsigned M2 =
        ((longint'(1) << S2) + longint'(BLOCK_NIDS) - 1) / BLOCK_NIDS;

    logic                 qa_v_reg;
    region_t              qa_region_reg;
    logic [SlotW-1:0]     qa_slot0_reg;
    logic [RelW-1:0]      qa_rel_reg;
    logic [QW-1:0]        qa_q_reg;
    logic [QW-1:0]        qa_q_next;
    logic [PW1-1:0]       prod1;
    logic                 qa_ready;

    logic                 qb_v_reg;
    region_t              qb_region_reg;
    logic [SlotW-1:0]     qb_slot0_reg;
    logic [RW-1:0]        qb_rem_reg;
    logic [RW-1:0]        qb_rem_next;
    logic [QW-1:0]        qb_q_reg;
    logic [NW-1:0]        qb_nid_reg;
    logic [NW-1:0]        qb_nid_next;
    logic [RelW-1:0]      rem_full;
    logic [PW2-1:0]       prod2;

    assign qa_ready = !qb_v_reg || out_ready;
    assign in_ready = !qa_v_reg || qa_ready;

    // Quotient of the offset by the node block size
    assign prod1     = PW1'(rel) * PW1'(M1);
    assign qa_q_next = prod1[PW1-1:S1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qa_v_reg <= 1'b0;
        else if (in_ready)
            qa_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            qa_region_reg <= in_region;
            qa_slot0_reg  <= in_slot0;
            qa_rel_reg    <= rel;
            qa_q_reg      <= qa_q_next;
        end
    end

    // Remainder by the block size and quotient by the pointer count
    assign rem_full    = qa_rel_reg - RelW'(qa_q_reg) * RelW'(BLOCK_ADDRS);
    assign qb_rem_next = rem_full[RW-1:0];
    assign prod2       = PW2'(qa_q_reg) * PW2'(M2);
    assign qb_nid_next = prod2[PW2-1:S2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qb_v_reg <= 1'b0;
        else if (qa_ready)
            qb_v_reg <= qa_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (qa_v_reg && qa_ready)
        begin
            qb_region_reg <= qa_region_reg;
            qb_slot0_reg  <= qa_slot0_reg;
            qb_rem_reg    <= qb_rem_next;
            qb_q_reg      <= qa_q_reg;
            qb_nid_reg    <= qb_nid_next;
        end
    end

    assign out_valid  = qb_v_reg;
    assign out_region = qb_region_reg;
    assign out_slot0  = qb_slot0_reg;
    assign rem_addr   = qb_rem_reg;
    assign q_all      = qb_q_reg;
    assign q_nid      = qb_nid_reg;

endmodule

// ----- hw/rtl/fbnp_assemble.sv -----
// Result assembly and output register.
// Builds depth, slots and node offsets per region and holds the response.
// Depends on fbnp_pkg.
module fbnp_assemble #(
    parameter int INODE_ADDRS = fbnp_pkg::DefInodeAddrs,
    parameter int BLOCK_ADDRS = fbnp_pkg::DefBlockAddrs,
    parameter int BLOCK_NIDS  = fbnp_pkg::DefBlockNids,
    localparam int QW = $clog2(BLOCK_NIDS * BLOCK_NIDS),
    localparam int NW = $clog2(BLOCK_NIDS),
    localparam int RW = $clog2(BLOCK_ADDRS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbnp_pkg::region_t             region,
    input  logic [fbnp_pkg::SlotW-1:0]    slot0,
    input  logic [RW-1:0]                 rem_addr,
    input  logic [QW-1:0]                 q_all,
    input  logic [NW-1:0]                 q_nid,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbnp_pkg::out_item_t           item
);
    import fbnp_pkg::*;

    localparam int OW = $clog2(8 + 3 * BLOCK_NIDS + BLOCK_NIDS * BLOCK_NIDS);

    logic              out_v_reg;
    out_item_t         item_reg;
    out_item_t         item_next;
    logic [NW-1:0]     q_sub;
    logic [OW-1:0]     dind_step;
    logic [OW-1:0]     dind_off2;
    logic [OW-1:0]     dind_off3;
    logic [OW-1:0]     ind0_off2;
    logic [OW-1:0]     ind1_off2;

    assign in_ready = !out_v_reg || out_ready;

    // Slot in the second-level node and the node offsets derived from it
    assign q_sub     = NW'(q_all - QW'(q_nid) * QW'(BLOCK_NIDS));
    assign dind_step = OW'(q_nid) * OW'(BLOCK_NIDS + 1);
    assign dind_off2 = OW'(6 + 2 * BLOCK_NIDS) + dind_step;
    assign dind_off3 = dind_off2 + OW'(1) + OW'(q_sub);
    assign ind0_off2 = OW'(4) + OW'(q_all);
    assign ind1_off2 = OW'(5 + BLOCK_NIDS) + OW'(q_all);

    // Fill the fields used at this depth; the rest stay zero
    always_comb
    begin
        item_next       = '0;
        item_next.slot0 = slot0;
        case (region)
            REGION_DIRECT:
            begin
                item_next.depth = DEPTH_DIRECT;
            end
            REGION_DNODE0:
            begin
                item_next.depth     = DEPTH_DNODE;
                item_next.slot1     = SlotW'(rem_addr);
                item_next.node_off1 = Off1W'(1);
            end
            REGION_DNODE1:
            begin
                item_next.depth     = DEPTH_DNODE;
                item_next.slot1     = SlotW'(rem_addr);
                item_next.node_off1 = Off1W'(2);
            end
            REGION_IND0:
            begin
                item_next.depth     = DEPTH_IND;
                item_next.slot1     = SlotW'(q_all);
                item_next.slot2     = SlotW'(rem_addr);
                item_next.node_off1 = Off1W'(3);
                item_next.node_off2 = OffW'(ind0_off2);
            end
            REGION_IND1:
            begin
                item_next.depth     = DEPTH_IND;
                item_next.slot1     = SlotW'(q_all);
                item_next.slot2     = SlotW'(rem_addr);
                item_next.node_off1 = Off1W'(4 + BLOCK_NIDS);
                item_next.node_off2 = OffW'(ind1_off2);
            end
            REGION_DIND:
            begin
                item_next.depth     = DEPTH_DIND;
                item_next.slot1     = SlotW'(q_nid);
                item_next.slot2     = SlotW'(q_sub);
                item_next.slot3     = SlotW'(rem_addr);
                item_next.node_off1 = Off1W'(5 + 2 * BLOCK_NIDS);
                item_next.node_off2 = OffW'(dind_off2);
                item_next.node_off3 = OffW'(dind_off3);
            end
            REGION_RANGE_ERR:
            begin
                item_next              = '0;
                item_next.out_of_range = 1'b1;
            end
            default:
            begin
                item_next              = '0;
                item_next.out_of_range = 1'b1;
            end
        endcase
    end

    // Hold the response until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (in_ready)
            out_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

    assign out_valid = out_v_reg;
    assign item      = item_reg;

endmodule
